[design/blc_pkg.sv]
// Shared types and constants for the dual LED blink controller.
`timescale 1ns / 1ps

package blc_pkg;

  localparam int unsigned CountW  = 8;
  localparam int unsigned ToggleW = CountW + 1;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OFF  = 2'd0,
    STATUS_ON   = 2'd1,
    STATUS_SLOW = 2'd2,
    STATUS_FAST = 2'd3
  } status_e;

  // Command seen by every channel for one beat.
  typedef struct packed {
    logic              is_set;
    logic              turn_on;
    logic [CountW-1:0] blink_count;
    logic              fast;
    logic              phase_even;  // phase after this tick is 0
  } cmd_t;

endpackage

[design/blc_channel.sv]
// Per-LED state: steady level, blink flags, toggle counter and pin level.
`timescale 1ns / 1ps

module blc_channel (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             set_hit_i,
  input  blc_pkg::cmd_t    cmd_i,
  output logic             level_d_o,
  output blc_pkg::status_e status_d_o
);

  logic                        pin_q, pin_d;
  logic                        steady_q, steady_d;
  logic                        blink_q, blink_d;
  logic                        fast_q, fast_d;
  logic [blc_pkg::ToggleW-1:0] toggles_q, toggles_d;

  always_comb begin
    pin_d     = pin_q;
    steady_d  = steady_q;
    blink_d   = blink_q;
    fast_d    = fast_q;
    toggles_d = toggles_q;
    if (step_i) begin
      if (cmd_i.is_set) begin
        if (set_hit_i) begin
          if (cmd_i.blink_count != '0) begin
            if (cmd_i.turn_on) begin
              blink_d   = 1'b1;
              fast_d    = cmd_i.fast;
              toggles_d = {cmd_i.blink_count, 1'b0};
            end else begin
              blink_d   = 1'b0;
              fast_d    = 1'b0;
              toggles_d = '0;
              pin_d     = steady_q;
            end
          end else begin
            steady_d = cmd_i.turn_on;
            if (!blink_q) begin
              pin_d = cmd_i.turn_on;
            end
          end
        end
      end else if (blink_q && (fast_q || cmd_i.phase_even)) begin
        if (toggles_q != '0) begin
          pin_d     = ~pin_q;
          toggles_d = toggles_q - blc_pkg::ToggleW'(1);
        end else begin
          blink_d = 1'b0;
          fast_d  = 1'b0;
          pin_d   = steady_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q     <= 1'b0;
      steady_q  <= 1'b0;
      blink_q   <= 1'b0;
      fast_q    <= 1'b0;
      toggles_q <= '0;
    end else begin
      pin_q     <= pin_d;
      steady_q  <= steady_d;
      blink_q   <= blink_d;
      fast_q    <= fast_d;
      toggles_q <= toggles_d;
    end
  end

  // Report the state as it stands after this beat.
  assign level_d_o = pin_d;

  always_comb begin
    if (blink_d) begin
      status_d_o = fast_d ? blc_pkg::STATUS_FAST : blc_pkg::STATUS_SLOW;
    end else begin
      status_d_o = steady_d ? blc_pkg::STATUS_ON : blc_pkg::STATUS_OFF;
    end
  end

endmodule

[design/dual_led_blink_controller.sv]
// Top level of the dual LED blink controller: input register, channel update, result register.
// A beat is accepted into the input register, then moves into the result register unless held.
// Throughput: one beat per cycle unless stalled; each LED's update is a single short step.
// A waiting result does not block intake while the input register is free.
// Reset (rst_ni low, asynchronous): all LEDs off, not blinking, phase 0, both stages empty.
`timescale 1ns / 1ps

module dual_led_blink_controller #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command/tick channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic                        led_select_i,
  input  logic                        turn_on_i,
  input  logic [blc_pkg::CountW-1:0]  blink_count_i,
  input  logic                        fast_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        pending_level_o,
  output logic                        upload_level_o,
  output logic [1:0]                  pending_status_o,
  output logic [1:0]                  upload_status_o
);

  // ---------------------------------------------------------------------------
  // Input register: hold one beat until the result register can take it.
  // ---------------------------------------------------------------------------
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_func_q;
  logic                       s1_sel_q;
  logic                       s1_on_q;
  logic [blc_pkg::CountW-1:0] s1_count_q;
  logic                       s1_fast_q;

  logic out_valid_q, out_valid_d;
  logic out_hold;   // result register full and stalled
  logic in_accept;
  logic s1_fire;    // beat moves from the input register into the result register

  assign out_hold   = out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && out_hold;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && !out_hold;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q  <= func_i;
      s1_sel_q   <= led_select_i;
      s1_on_q    <= turn_on_i;
      s1_count_q <= blink_count_i;
      s1_fast_q  <= fast_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tick phase: flip on every tick beat.
  // ---------------------------------------------------------------------------
  logic phase_q, phase_d;
  logic is_tick;

  assign is_tick = (s1_func_q == blc_pkg::FUNC_TICK);
  assign phase_d = (s1_fire && is_tick) ? ~phase_q : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Channels: each updates its own state when the beat fires.
  // ---------------------------------------------------------------------------
  blc_pkg::cmd_t    cmd;
  logic             lvl_d    [CHANNELS];
  blc_pkg::status_e status_d [CHANNELS];

  assign cmd.is_set      = (s1_func_q == blc_pkg::FUNC_SET);
  assign cmd.turn_on     = s1_on_q;
  assign cmd.blink_count = s1_count_q;
  assign cmd.fast        = s1_fast_q;
  assign cmd.phase_even  = ~phase_d;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    logic hit;
    // Only the pending and upload LEDs are reachable by the select field.
    if (g < 2) begin : g_addr
      assign hit = (s1_sel_q == 1'(g));
    end else begin : g_noaddr
      assign hit = 1'b0;
    end

    blc_channel u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (s1_fire),
      .set_hit_i  (hit),
      .cmd_i      (cmd),
      .level_d_o  (lvl_d[g]),
      .status_d_o (status_d[g])
    );
  end

  // A missing upload channel reads as off.
  logic       up_lvl;
  logic [1:0] up_status;

  if (CHANNELS > 1) begin : g_up
    assign up_lvl    = lvl_d[1];
    assign up_status = 2'(status_d[1]);
  end else begin : g_noup
    assign up_lvl    = 1'b0;
    assign up_status = 2'(blc_pkg::STATUS_OFF);
  end

  // ---------------------------------------------------------------------------
  // Result register: capture post-update levels and status on every fired beat.
  // ---------------------------------------------------------------------------
  logic       pend_lvl_q, up_lvl_q;
  logic [1:0] pend_status_q, up_status_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pend_lvl_q    <= lvl_d[0];
      up_lvl_q      <= up_lvl;
      pend_status_q <= 2'(status_d[0]);
      up_status_q   <= up_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pending_level_o  = pend_lvl_q;
  assign upload_level_o   = up_lvl_q;
  assign pending_status_o = pend_status_q;
  assign upload_status_o  = up_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A fired beat always lands in the result register.
  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("fired beat did not reach the result register");

  // Intake stalls only when both stages hold a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("intake stalled with a free stage");

  // The phase flips on exactly the tick beats.
  a_phase_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && is_tick) |=> (phase_q != $past(phase_q)))
    else $error("tick phase did not flip on a tick");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && is_tick) |=> $stable(phase_q))
    else $error("tick phase moved without a tick");

endmodule
